// File: rtl/sbck_pkg.sv
// Shared types and constants for the color-keyed sprite blit block.
package sbck_pkg;

    localparam int DEF_FRAME_W = 640;
    localparam int DEF_FRAME_H = 480;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_X        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_Y        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd4;

    localparam logic [31:0] KEY_MASK = 32'h0000_00FF;

    localparam logic [9:0] RST_SPRITE_WIDTH  = 10'd64;
    localparam logic [8:0] RST_SPRITE_HEIGHT = 9'd64;

    typedef struct packed {
        logic [31:0] frame_base;
        logic [9:0]  dest_x;
        logic [8:0]  dest_y;
        logic [9:0]  sprite_width;
        logic [8:0]  sprite_height;
    } t_cfg;

    typedef struct packed {
        logic [9:0] col;
        logic [8:0] row;
    } t_pos;

endpackage

// File: rtl/sbck_scan.sv
// Column and row counters that walk the sprite in row-major order.
module sbck_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  sbck_pkg::t_cfg i_cfg,
    output sbck_pkg::t_pos o_pos,
    output logic          o_empty
);
    import sbck_pkg::*;

    t_pos        r_pos;
    t_pos        n_pos;
    logic [10:0] row_len;
    logic        col_last;
    logic        row_last;

    // Rows are padded to a multiple of eight pixels.
    assign row_len  = (11'(i_cfg.sprite_width) + 11'd7) & ~11'd7;
    assign o_empty  = (row_len == 11'd0) || (i_cfg.sprite_height == 9'd0);
    assign col_last = (11'(r_pos.col) + 11'd1) >= row_len;
    assign row_last = (10'(r_pos.row) + 10'd1) >= 10'(i_cfg.sprite_height);

    always_comb begin
        n_pos = r_pos;
        if (o_empty) begin
            n_pos.col = '0;
            n_pos.row = '0;
        end else if (col_last) begin
            n_pos.col = '0;
            n_pos.row = row_last ? 9'd0 : r_pos.row + 9'd1;
        end else begin
            n_pos.col = r_pos.col + 10'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_step) begin
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;

`ifndef SYNTH
    a_empty_holds_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_empty) |=> (r_pos.col == 10'd0 && r_pos.row == 9'd0))
        else $error("counters not cleared on an empty sprite");
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_pos))
        else $error("counters moved without a word");
    a_wrap_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !o_empty && col_last && row_last)
        |=> (r_pos.col == 10'd0 && r_pos.row == 9'd0))
        else $error("counters did not wrap after the last pixel");
`endif

endmodule

// File: rtl/sprite_blit_color_key.sv
// Top level of the color-keyed sprite blit: config registers and the two-stage datapath.
//
//   channel   direction  handshake                    payload
//   src       in         i_src_valid / o_src_stall    i_src_pixel
//   wr        out        o_wr_valid  / i_wr_stall     o_write_addr, o_write_data
//   cfg       in         i_cfg_we                     i_cfg_idx, i_cfg_data
//
// One source word is taken every cycle while o_src_stall is low; a write follows its word
// through the input register and the address register (one constant multiply and adds).
// Reset is synchronous, clears the counters and valid flags and loads the config
// registers with their reset values.
// A stall on the write side backs up through the two stages; the source side stalls
// only when both stages are full and the write side is stalled.
module sprite_blit_color_key #(
    parameter int FRAME_W = sbck_pkg::DEF_FRAME_W,
    parameter int FRAME_H = sbck_pkg::DEF_FRAME_H
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sbck_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_src_valid,
    output logic                           o_src_stall,
    input  logic [31:0]                    i_src_pixel,
    output logic                           o_wr_valid,
    input  logic                           i_wr_stall,
    output logic [31:0]                    o_write_addr,
    output logic [31:0]                    o_write_data
);
    import sbck_pkg::*;

    t_cfg        r_cfg;
    t_pos        pos;
    logic        empty;
    logic        src_acc;
    logic        s1_en;
    logic        out_free;
    logic        in_frame;
    logic        n_s1_wr;
    logic [10:0] x_end;
    logic [9:0]  y_end;
    logic [9:0]  y_row;
    logic [31:0] row_base;
    logic [31:0] n_addr;

    logic        r_s1_valid;
    logic [31:0] r_s1_pix;
    t_pos        r_s1_pos;
    logic        r_o_valid;
    logic [31:0] r_o_addr;
    logic [31:0] r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_base    <= '0;
            r_cfg.dest_x        <= '0;
            r_cfg.dest_y        <= '0;
            r_cfg.sprite_width  <= RST_SPRITE_WIDTH;
            r_cfg.sprite_height <= RST_SPRITE_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_BASE:    r_cfg.frame_base    <= i_cfg_data;
                REG_DEST_X:        r_cfg.dest_x        <= i_cfg_data[9:0];
                REG_DEST_Y:        r_cfg.dest_y        <= i_cfg_data[8:0];
                REG_SPRITE_WIDTH:  r_cfg.sprite_width  <= i_cfg_data[9:0];
                REG_SPRITE_HEIGHT: r_cfg.sprite_height <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign out_free    = !r_o_valid || !i_wr_stall;
    assign s1_en       = !r_s1_valid || out_free;
    assign o_src_stall = !s1_en;
    assign src_acc     = i_src_valid && s1_en;

    sbck_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (src_acc),
        .i_cfg   (r_cfg),
        .o_pos   (pos),
        .o_empty (empty)
    );

    // A sprite crossing the right or bottom edge suppresses every write of the job.
    assign x_end    = 11'(r_cfg.dest_x) + 11'(r_cfg.sprite_width);
    assign y_end    = 10'(r_cfg.dest_y) + 10'(r_cfg.sprite_height);
    assign in_frame = (32'(x_end) <= 32'(FRAME_W)) && (32'(y_end) <= 32'(FRAME_H));
    assign n_s1_wr  = !empty && in_frame && ((i_src_pixel & KEY_MASK) != 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= src_acc && n_s1_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (src_acc) begin
            r_s1_pix <= i_src_pixel;
            r_s1_pos <= pos;
        end
    end

    assign y_row    = 10'(r_cfg.dest_y) + 10'(r_s1_pos.row);
    assign row_base = 32'(FRAME_W) * 32'(y_row);
    assign n_addr   = r_cfg.frame_base + row_base + 32'(r_cfg.dest_x) + 32'(r_s1_pos.col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_o_addr <= n_addr;
            r_o_data <= r_s1_pix;
        end
    end

    assign o_wr_valid   = r_o_valid;
    assign o_write_addr = r_o_addr;
    assign o_write_data = r_o_data;

`ifndef SYNTH
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_src_stall |-> (r_s1_valid && r_o_valid && i_wr_stall))
        else $error("source stalled with room in the pipeline");
    a_key_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (src_acc && ((i_src_pixel & KEY_MASK) == 32'd0)) |=> !r_s1_valid)
        else $error("transparent word entered the pipeline");
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_free) |=> o_wr_valid)
        else $error("write lost between stages");
`endif

endmodule
